[rtl/mss_pkg.sv]
// mss_pkg: shared types and constants for the mass-spring chain step block
// no dependencies
`timescale 1ns / 1ps
package mss_pkg;
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	localparam logic [2:0] REG_MODE  = 3'd0;
	localparam logic [2:0] REG_COUNT = 3'd1;
	localparam logic [2:0] REG_DT    = 3'd2;
	localparam logic [2:0] REG_GX    = 3'd3;
	localparam logic [2:0] REG_GY    = 3'd4;
	localparam logic [2:0] REG_K     = 3'd5;
	localparam logic [2:0] REG_MASS  = 3'd6;
	localparam logic [2:0] REG_REST  = 3'd7;

	localparam logic signed [31:0] SMAX = 32'sh7fffffff;
	localparam logic signed [31:0] SMIN = 32'sh80000000;

	typedef struct packed {
		logic mode;
		logic [30:0] dt;
		logic signed [31:0] gx;
		logic signed [31:0] gy;
		logic [30:0] k;
		logic [30:0] mass;
		logic [30:0] rest;
	} cfg_t;

	// controller commands
	typedef enum logic [2:0] {
		CMD_NONE, CMD_LOAD, CMD_SPRING, CMD_NODE, CMD_EMIT
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t op;
		logic start;
		logic [5:0] idx;
	} cmd_t;

	typedef struct packed {
		logic done;
	} sts_t;

	function automatic logic signed [31:0] sat64(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return SMAX;
		if (v < -66'sd2147483648) return SMIN;
		return v[31:0];
	endfunction
endpackage

[rtl/mss_divider.sv]
// mss_divider: signed 64 by unsigned 32 restoring divider, one quotient bit per cycle
// no dependencies
`timescale 1ns / 1ps
module mss_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] num,
	input  logic        [31:0] den,
	output logic               done,
	output logic signed [63:0] quot
);
	logic [63:0] q_q;
	logic [31:0] r_q;
	logic [6:0]  cnt_q;
	logic        neg_q, run_q;
	logic [31:0] d_q;
	logic [32:0] trial;
	logic [33:0] diff;

	assign trial = {r_q, q_q[63]};
	assign diff = {1'b0, trial} - {2'b0, d_q};
	assign quot = neg_q ? -$signed(q_q) : $signed(q_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 7'd64;
			end else if (run_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num[63] ? 64'(-num) : num;
			neg_q <= num[63];
			d_q <= den;
			r_q <= '0;
		end else if (run_q) begin
			if (!diff[33]) begin
				r_q <= diff[31:0];
				q_q <= {q_q[62:0], 1'b1};
			end else begin
				r_q <= trial[31:0];
				q_q <= {q_q[62:0], 1'b0};
			end
		end
	end
endmodule

[rtl/mss_datapath.sv]
// mss_datapath: node stores and sequenced spring and integration arithmetic
// depends on mss_pkg and mss_divider
`timescale 1ns / 1ps
module mss_datapath #(
	parameter int MAX_NODES = 16,
	parameter int FRAC_BITS = 16,
	parameter int IW = $clog2(MAX_NODES)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mss_pkg::cfg_t       cfg,
	input  mss_pkg::cmd_t       cmd,
	input  logic [IW-1:0]       ld_idx,
	input  logic signed [31:0]  ld_x,
	input  logic signed [31:0]  ld_y,
	input  logic                ld_pin,
	output mss_pkg::sts_t       sts,
	output logic signed [31:0]  rd_x,
	output logic signed [31:0]  rd_y
);
	logic signed [31:0] px_q [MAX_NODES];
	logic signed [31:0] py_q [MAX_NODES];
	logic signed [31:0] qx_q [MAX_NODES];
	logic signed [31:0] qy_q [MAX_NODES];
	logic signed [31:0] vx_q [MAX_NODES];
	logic signed [31:0] vy_q [MAX_NODES];
	logic signed [31:0] fx_q [MAX_NODES];
	logic signed [31:0] fy_q [MAX_NODES];
	logic [MAX_NODES-1:0] pin_q;

	logic [4:0]  ph_q;
	logic [IW-1:0] a_q, b_q;
	logic signed [31:0] dx_q, dy_q, fm_q, t_q, acc_q;
	logic signed [32:0] dr_q;
	logic signed [63:0] w_q;
	logic [63:0] rem_q;
	logic [31:0] root_q;
	logic [4:0] sq_q;
	logic axis_q, busy_q;
	logic div_start, div_done;
	logic signed [63:0] div_num, div_q;
	logic [31:0] div_den;
	logic [31:0] mass_eff;
	logic signed [31:0] ma;
	logic signed [32:0] mb;
	logic signed [63:0] prod;
	logic signed [31:0] pa, qa, va, fa, ga, qsum;
	logic [31:0] trial_sq;

	localparam logic [4:0] P_IDLE = 5'd0, P_SQ1 = 5'd1, P_SQ2 = 5'd2, P_ROOT = 5'd3,
		P_FM = 5'd4, P_FMW = 5'd5, P_DIVX = 5'd6, P_DIVXW = 5'd7, P_DIVY = 5'd8,
		P_DIVYW = 5'd9, P_ACC = 5'd10, P_ACCEL = 5'd11, P_ACCW = 5'd12, P_ADDG = 5'd13,
		P_M1 = 5'd14, P_M1W = 5'd15, P_M2 = 5'd16, P_M2W = 5'd17, P_WR = 5'd18;

	assign mass_eff = (cfg.mass == '0) ? 32'd1 : {1'b0, cfg.mass};
	assign div_den = (ph_q == P_ACCEL) ? mass_eff : root_q;
	assign div_start = (ph_q == P_DIVX) || (ph_q == P_DIVY) || (ph_q == P_ACCEL);
	assign prod = ma * mb;
	assign sts.done = busy_q && (ph_q == P_IDLE);
	assign rd_x = px_q[cmd.idx[IW-1:0]];
	assign rd_y = py_q[cmd.idx[IW-1:0]];
	assign pa = axis_q ? py_q[a_q] : px_q[a_q];
	assign qa = axis_q ? qy_q[a_q] : qx_q[a_q];
	assign va = axis_q ? vy_q[a_q] : vx_q[a_q];
	assign fa = axis_q ? fy_q[a_q] : fx_q[a_q];
	assign ga = axis_q ? cfg.gy : cfg.gx;
	assign trial_sq = root_q | (32'd1 << sq_q);

	always_comb begin
		ma = dx_q;
		mb = 33'(dx_q);
		div_num = '0;
		case (ph_q)
			P_SQ1: begin ma = dx_q; mb = 33'(dx_q); end
			P_SQ2: begin ma = dy_q; mb = 33'(dy_q); end
			P_FMW: begin ma = $signed({1'b0, cfg.k}); mb = dr_q; end
			P_DIVX: begin ma = fm_q; mb = 33'(dx_q); end
			P_DIVY: begin ma = fm_q; mb = 33'(dy_q); end
			P_M1: begin ma = acc_q; mb = $signed({2'b0, cfg.dt}); end
			P_M2: begin ma = t_q; mb = $signed({2'b0, cfg.dt}); end
			default: begin ma = dx_q; mb = 33'(dx_q); end
		endcase
		case (ph_q)
			P_DIVX, P_DIVY: div_num = prod;
			P_ACCEL: div_num = 64'(fa) <<< FRAC_BITS;
			default: div_num = '0;
		endcase
	end

	mss_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .done(div_done), .quot(div_q)
	);

	function automatic logic signed [31:0] qdiv(input logic signed [63:0] p);
		logic signed [63:0] s;
		s = p + (p[63] ? 64'((64'sd1 <<< FRAC_BITS) - 1) : 64'sd0);
		return mss_pkg::sat64(66'(s >>> FRAC_BITS));
	endfunction

	assign qsum = qdiv(prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= P_IDLE;
			busy_q <= 1'b0;
			pin_q <= '0;
			for (int i = 0; i < MAX_NODES; i++) begin
				fx_q[i] <= '0;
				fy_q[i] <= '0;
			end
		end else begin
			if (cmd.start) busy_q <= 1'b1;
			if (sts.done) busy_q <= 1'b0;
			case (ph_q)
				P_IDLE: begin
					if (cmd.start && cmd.op == mss_pkg::CMD_LOAD) begin
						px_q[ld_idx] <= ld_x;
						py_q[ld_idx] <= ld_y;
						qx_q[ld_idx] <= ld_x;
						qy_q[ld_idx] <= ld_y;
						vx_q[ld_idx] <= '0;
						vy_q[ld_idx] <= '0;
						pin_q[ld_idx] <= ld_pin;
					end else if (cmd.start && cmd.op == mss_pkg::CMD_SPRING) begin
						a_q <= cmd.idx[IW-1:0];
						b_q <= IW'(cmd.idx + 6'd1);
						dx_q <= mss_pkg::sat64(66'(px_q[IW'(cmd.idx + 6'd1)])
							- 66'(px_q[cmd.idx[IW-1:0]]));
						dy_q <= mss_pkg::sat64(66'(py_q[IW'(cmd.idx + 6'd1)])
							- 66'(py_q[cmd.idx[IW-1:0]]));
						ph_q <= P_SQ1;
					end else if (cmd.start && cmd.op == mss_pkg::CMD_NODE) begin
						a_q <= cmd.idx[IW-1:0];
						axis_q <= 1'b0;
						ph_q <= pin_q[cmd.idx[IW-1:0]] ? P_WR : P_ACCEL;
					end
				end
				P_SQ1: begin w_q <= prod; ph_q <= P_SQ2; end
				P_SQ2: begin
					rem_q <= 64'(w_q) + 64'(prod);
					root_q <= '0;
					sq_q <= 5'd31;
					ph_q <= P_ROOT;
				end
				P_ROOT: begin
					// bitwise root, one result bit per cycle
					if (64'(trial_sq) * 64'(trial_sq) <= rem_q) root_q <= trial_sq;
					if (sq_q == 5'd0) ph_q <= P_FM;
					sq_q <= sq_q - 5'd1;
				end
				P_FM: begin
					if (root_q == '0) ph_q <= P_IDLE;
					else begin
						dr_q <= $signed({1'b0, root_q}) - $signed({2'b0, cfg.rest});
						ph_q <= P_FMW;
					end
				end
				P_FMW: begin fm_q <= qdiv(prod); ph_q <= P_DIVX; end
				P_DIVX: ph_q <= P_DIVXW;
				P_DIVXW: if (div_done) begin w_q <= div_q; ph_q <= P_DIVY; end
				P_DIVY: ph_q <= P_DIVYW;
				P_DIVYW: if (div_done) begin
					fx_q[a_q] <= mss_pkg::sat64(66'(fx_q[a_q]) + 66'(w_q));
					fx_q[b_q] <= mss_pkg::sat64(66'(fx_q[b_q]) - 66'(w_q));
					fy_q[a_q] <= mss_pkg::sat64(66'(fy_q[a_q]) + 66'(div_q));
					fy_q[b_q] <= mss_pkg::sat64(66'(fy_q[b_q]) - 66'(div_q));
					ph_q <= P_IDLE;
				end
				P_ACCEL: ph_q <= P_ACCW;
				P_ACCW: if (div_done) begin
					acc_q <= mss_pkg::sat64(66'(div_q));
					ph_q <= P_ADDG;
				end
				P_ADDG: begin
					acc_q <= mss_pkg::sat64(66'(acc_q) + 66'(ga));
					ph_q <= P_M1;
				end
				P_M1: begin t_q <= qdiv(prod); ph_q <= P_M1W; end
				P_M1W: begin
					if (cfg.mode) ph_q <= P_M2;
					else begin
						t_q <= mss_pkg::sat64(66'(va) + 66'(t_q));
						if (axis_q) vy_q[a_q] <= mss_pkg::sat64(66'(va) + 66'(t_q));
						else vx_q[a_q] <= mss_pkg::sat64(66'(va) + 66'(t_q));
						ph_q <= P_M2;
					end
				end
				P_M2: begin
					if (cfg.mode) begin
						if (axis_q) begin
							py_q[a_q] <= mss_pkg::sat64(66'(pa) * 66'sd2 - 66'(qa)
								+ 66'(qsum));
							qy_q[a_q] <= pa;
						end else begin
							px_q[a_q] <= mss_pkg::sat64(66'(pa) * 66'sd2 - 66'(qa)
								+ 66'(qsum));
							qx_q[a_q] <= pa;
						end
					end else begin
						if (axis_q) begin
							py_q[a_q] <= mss_pkg::sat64(66'(pa) + 66'(qsum));
							qy_q[a_q] <= pa;
						end else begin
							px_q[a_q] <= mss_pkg::sat64(66'(pa) + 66'(qsum));
							qx_q[a_q] <= pa;
						end
					end
					if (axis_q) ph_q <= P_WR;
					else begin axis_q <= 1'b1; ph_q <= P_ACCEL; end
				end
				P_WR: begin
					fx_q[a_q] <= '0;
					fy_q[a_q] <= '0;
					ph_q <= P_IDLE;
				end
				default: ph_q <= P_IDLE;
			endcase
		end
	end
endmodule

[rtl/mss_control.sv]
// mss_control: load forwarding and step sequencer over springs, nodes and result emission
// depends on mss_pkg
`timescale 1ns / 1ps
module mss_control #(
	parameter int MAX_NODES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          opcode,
	input  logic [4:0]    count,
	input  mss_pkg::sts_t sts,
	output mss_pkg::cmd_t cmd,
	output logic          busy,
	output logic          emit,
	output logic          emit_last
);
	localparam logic [2:0] S_IDLE = 3'd0, S_SPR = 3'd1, S_SPRW = 3'd2, S_NODE = 3'd3,
		S_NODEW = 3'd4, S_EMIT = 3'd5;
	logic [2:0] st_q;
	logic [5:0] i_q, n_q, n_eff;

	always_comb begin
		n_eff = {1'b0, count};
		if (n_eff < 6'd2) n_eff = 6'd2;
		if (int'(n_eff) > MAX_NODES) n_eff = 6'(MAX_NODES);
	end

	assign busy = st_q != S_IDLE;
	assign emit = st_q == S_EMIT;
	assign emit_last = emit && (i_q + 6'd1 == n_q);

	always_comb begin
		cmd.start = 1'b0;
		cmd.op = mss_pkg::CMD_NONE;
		cmd.idx = i_q;
		case (st_q)
			S_IDLE: if (start && opcode == mss_pkg::OP_LOAD) begin
				cmd.start = 1'b1;
				cmd.op = mss_pkg::CMD_LOAD;
			end
			S_SPR: begin cmd.start = 1'b1; cmd.op = mss_pkg::CMD_SPRING; end
			S_NODE: begin cmd.start = 1'b1; cmd.op = mss_pkg::CMD_NODE; end
			S_EMIT: cmd.op = mss_pkg::CMD_EMIT;
			default: cmd.op = mss_pkg::CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			i_q <= '0;
			n_q <= 6'd2;
		end else begin
			case (st_q)
				S_IDLE: if (start && opcode == mss_pkg::OP_STEP) begin
					n_q <= n_eff;
					i_q <= '0;
					st_q <= S_SPR;
				end
				S_SPR: st_q <= S_SPRW;
				S_SPRW: if (sts.done) begin
					if (i_q + 6'd2 == n_q) begin i_q <= '0; st_q <= S_NODE; end
					else begin i_q <= i_q + 6'd1; st_q <= S_SPR; end
				end
				S_NODE: st_q <= S_NODEW;
				S_NODEW: if (sts.done) begin
					if (i_q + 6'd1 == n_q) begin i_q <= '0; st_q <= S_EMIT; end
					else begin i_q <= i_q + 6'd1; st_q <= S_NODE; end
				end
				S_EMIT: begin
					if (emit_last) st_q <= S_IDLE;
					i_q <= i_q + 6'd1;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

[rtl/mass_spring_chain_step.sv]
// mass_spring_chain_step: top level, config registers, controller and datapath
// depends on mss_pkg, mss_control, mss_datapath
//
// channel | signals                                        | handshake
// input   | opcode node_index load_x load_y load_pinned    | start && !busy
// result  | out_index out_x out_y last_node                | result_valid, one cycle
// config  | cfg_we cfg_index cfg_data                      | cfg_we
//
// a load is written at its accepting edge, then busy is high for a single cycle.
// a step runs each spring through the bitwise root loop and serial divider (no
// force when its length is zero), then each unpinned node through the divider
// (pinned ones only clear forces), then one result per cycle, each in the cycle
// after its slot. reset clears forces and pinned flags and restores config
// defaults; positions are undefined until loaded. results cannot be stalled.
`timescale 1ns / 1ps
module mass_spring_chain_step #(
	parameter int MAX_NODES = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               opcode,
	input  logic [3:0]         node_index,
	input  logic signed [31:0] load_x,
	input  logic signed [31:0] load_y,
	input  logic               load_pinned,
	output logic               result_valid,
	output logic [3:0]         out_index,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic               last_node,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	localparam int IW = $clog2(MAX_NODES);
	mss_pkg::cfg_t cfg_q;
	logic [4:0] count_q;
	mss_pkg::cmd_t cmd;
	mss_pkg::sts_t sts;
	logic ctl_busy, dp_busy_q, emit, emit_last, go, ld_ok;
	logic signed [31:0] rd_x, rd_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= 1'b0;
			count_q <= 5'd16;
			cfg_q.dt <= 31'd65;
			cfg_q.gx <= '0;
			cfg_q.gy <= '0;
			cfg_q.k <= 31'd65536;
			cfg_q.mass <= 31'd65536;
			cfg_q.rest <= 31'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				mss_pkg::REG_MODE:  cfg_q.mode <= cfg_data[0];
				mss_pkg::REG_COUNT: count_q <= cfg_data[4:0];
				mss_pkg::REG_DT:    cfg_q.dt <= cfg_data[30:0];
				mss_pkg::REG_GX:    cfg_q.gx <= cfg_data;
				mss_pkg::REG_GY:    cfg_q.gy <= cfg_data;
				mss_pkg::REG_K:     cfg_q.k <= cfg_data[30:0];
				mss_pkg::REG_MASS:  cfg_q.mass <= cfg_data[30:0];
				mss_pkg::REG_REST:  cfg_q.rest <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dp_busy_q <= 1'b0;
		else dp_busy_q <= go && opcode == mss_pkg::OP_LOAD;
	end

	assign busy = ctl_busy || dp_busy_q;
	assign ld_ok = int'(node_index) < MAX_NODES;
	assign go = start && !busy && (opcode == mss_pkg::OP_STEP || ld_ok);

	mss_control #(.MAX_NODES(MAX_NODES)) u_ctl (
		.clk(clk), .arst_n(arst_n), .start(go), .opcode(opcode), .count(count_q),
		.sts(sts), .cmd(cmd), .busy(ctl_busy), .emit(emit), .emit_last(emit_last)
	);

	mss_datapath #(.MAX_NODES(MAX_NODES), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .cmd(cmd),
		.ld_idx(IW'(node_index)), .ld_x(load_x), .ld_y(load_y),
		.ld_pin(load_pinned), .sts(sts), .rd_x(rd_x), .rd_y(rd_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else result_valid <= emit;
	end

	always_ff @(posedge clk) begin
		out_index <= cmd.idx[3:0];
		out_x <= rd_x;
		out_y <= rd_y;
		last_node <= emit_last;
	end
endmodule
